>>> rtl/core/spmtx_pkg.sv
// Package for the sensor packet Manchester transmitter.
// Holds item types, register indexes, packet constants and the temperature scale reciprocal.
// No dependencies.
`default_nettype none

package spmtx_pkg;

    localparam int PREAMBLE_BITS = 32;
    localparam int TEMP_SCALE    = 28;
    localparam int PAYLOAD_BITS  = 32;
    localparam int START_BITS    = 8;
    localparam int PACKET_BITS   = PREAMBLE_BITS + START_BITS + PAYLOAD_BITS;
    localparam int POS_W         = $clog2(PACKET_BITS + 1);

    localparam logic [7:0] START_CODE = 8'hAA;

    // floor(x / TEMP_SCALE) == (x * RECIP) >> RECIP_SHIFT for every 16-bit x
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + TEMP_SCALE - 1) / TEMP_SCALE);
    localparam int PROD_W = 16 + RECIP_W;

    localparam logic [7:0]  STATION_ID_RST = 8'd0;
    localparam logic [15:0] TEMP_LOW_RST   = 16'd28681;
    localparam logic [15:0] TEMP_HIGH_RST  = 16'd35807;
    localparam logic [7:0]  CODE_MAX       = 8'd255;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_STATION_ID = 2'd0,
        CFG_TEMP_LOW   = 2'd1,
        CFG_TEMP_HIGH  = 2'd2
    } spmtx_cfg_idx_t;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } spmtx_cmd_t;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        command;
        logic [15:0] temp_raw;
        logic [15:0] batt_raw;
    } spmtx_in_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic packet_end;
    } spmtx_out_t;

    // one classified item on its way from front to back
    typedef struct packed {
        logic                    is_load;
        logic [PAYLOAD_BITS-1:0] payload;
    } spmtx_entry_t;

endpackage

`default_nettype wire

>>> rtl/core/sensor_packet_manchester_tx_top.sv
// Top level of the sensor packet Manchester transmitter.
// Depends on spmtx_pkg, spmtx_front, spmtx_fifo, spmtx_back.
//
// Usage:
//   in channel  : one item per handshake; command LOAD builds the payload
//                 (station id, temperature code, battery code, XOR check) and
//                 starts a packet, command TICK emits one Manchester half-bit.
//                 A LOAD while a packet is in flight is ignored.
//   out channel : exactly one result per item, in order: line level, busy
//                 flag after the item, and a packet end flag on the last
//                 half-bit. The line reads 0 when idle and on LOAD items.
//   cfg channel : always ready; index 0 station id, 1 temp low, 2 temp high,
//                 other indexes ignored. Write only while no item is pending.
//   From input accept to result valid an item passes the intake register, a
//   queue entry and the result register.
//   Throughput is one item per cycle while the receiver does not stall, set by
//   the bit sequencer, which updates its state on every item it takes.
//   Reset clears all control state; registers take their reset values and
//   the block is idle with no result valid. When the receiver stalls, the result
//   register holds, the two-entry queue fills and in_ready drops after it.
`default_nettype none

module sensor_packet_manchester_tx_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire spmtx_pkg::spmtx_in_t              in_data,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output spmtx_pkg::spmtx_out_t                  out_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [spmtx_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [spmtx_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import spmtx_pkg::*;

    logic         push_valid;
    logic         push_ready;
    spmtx_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    spmtx_entry_t pop_entry;

    spmtx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    spmtx_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    spmtx_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/spmtx_front.sv
// Front end: configuration registers, item intake and payload building.
// Depends on spmtx_pkg.
`default_nettype none

module spmtx_front (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire spmtx_pkg::spmtx_in_t                 in_data,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [spmtx_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [spmtx_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                      push_valid,
    input  wire logic                                 push_ready,
    output spmtx_pkg::spmtx_entry_t                   push_entry
);
    import spmtx_pkg::*;

    logic [7:0]  station_id_reg;
    logic [15:0] temp_low_reg;
    logic [15:0] temp_high_reg;

    logic        a_valid_reg;
    logic        a_is_load_reg;
    logic        a_below_reg;
    logic        a_above_reg;
    logic [15:0] a_diff_reg;
    logic [7:0]  a_batt_reg;
    logic [7:0]  a_id_reg;

    logic              accept;
    logic [PROD_W-1:0] prod;
    logic [PROD_W-RECIP_SHIFT-1:0] quot;
    logic [7:0]        tcode;
    logic [7:0]        check;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_id_reg <= STATION_ID_RST;
            temp_low_reg   <= TEMP_LOW_RST;
            temp_high_reg  <= TEMP_HIGH_RST;
        end
        else if (cfg_valid)
        begin
            case (spmtx_cfg_idx_t'(cfg_index))
                CFG_STATION_ID: station_id_reg <= cfg_data[7:0];
                CFG_TEMP_LOW:   temp_low_reg   <= cfg_data;
                CFG_TEMP_HIGH:  temp_high_reg  <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign in_ready = !a_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_is_load_reg <= (in_data.command == CMD_LOAD);
            a_below_reg   <= in_data.temp_raw < temp_low_reg;
            a_above_reg   <= in_data.temp_raw > temp_high_reg;
            a_diff_reg    <= in_data.temp_raw - temp_low_reg;
            a_batt_reg    <= in_data.batt_raw[11:4];
            a_id_reg      <= station_id_reg;
        end
    end

    always_comb
    begin
        prod = PROD_W'(a_diff_reg) * PROD_W'(RECIP);
        quot = prod[PROD_W-1:RECIP_SHIFT];
        if (a_below_reg)
            tcode = 8'd0;
        else if (a_above_reg)
            tcode = CODE_MAX;
        else if (quot > (PROD_W-RECIP_SHIFT)'(CODE_MAX))
            tcode = CODE_MAX;
        else
            tcode = quot[7:0];
        check = a_id_reg ^ tcode ^ a_batt_reg;
    end

    assign push_valid         = a_valid_reg;
    assign push_entry.is_load = a_is_load_reg;
    assign push_entry.payload = {check, a_batt_reg, tcode, a_id_reg};

endmodule

`default_nettype wire

>>> rtl/core/spmtx_fifo.sv
// Two-entry queue of classified items between front and back.
// Depends on spmtx_pkg.
`default_nettype none

module spmtx_fifo (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push_valid,
    output logic                           push_ready,
    input  wire spmtx_pkg::spmtx_entry_t   push_entry,
    output logic                           pop_valid,
    input  wire logic                      pop_ready,
    output spmtx_pkg::spmtx_entry_t        pop_entry
);
    import spmtx_pkg::*;

    spmtx_entry_t            mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;
    logic                    do_push;
    logic                    do_pop;

    assign push_ready = count_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

>>> rtl/core/spmtx_back.sv
// Back end: packet sequencer, Manchester half-bit generation and result register.
// Depends on spmtx_pkg.
`default_nettype none

module spmtx_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      pop_valid,
    output logic                           pop_ready,
    input  wire spmtx_pkg::spmtx_entry_t   pop_entry,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output spmtx_pkg::spmtx_out_t          out_data
);
    import spmtx_pkg::*;

    logic                    sending_reg,  sending_next;
    logic                    half_reg,     half_next;
    logic [POS_W-1:0]        pos_reg,      pos_next;
    logic [PAYLOAD_BITS-1:0] payload_reg,  payload_next;
    logic                    out_valid_reg;
    spmtx_out_t              out_reg,      out_next;

    logic             take;
    logic             bit_val;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] start_off;
    logic [POS_W-1:0] data_off;

    assign pop_ready = !out_valid_reg || out_ready;
    assign take      = pop_valid && pop_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        start_off = pos_reg - POS_W'(PREAMBLE_BITS);
        data_off  = pos_reg - POS_W'(PREAMBLE_BITS + START_BITS);
        if (pos_reg < POS_W'(PREAMBLE_BITS))
            bit_val = 1'b1;
        else if (pos_reg < POS_W'(PREAMBLE_BITS + START_BITS))
            bit_val = START_CODE[start_off[2:0]];
        else
            bit_val = payload_reg[data_off[$clog2(PAYLOAD_BITS)-1:0]];
        pos_inc = pos_reg + 1'b1;
    end

    always_comb
    begin
        sending_next = sending_reg;
        half_next    = half_reg;
        pos_next     = pos_reg;
        payload_next = payload_reg;
        out_next     = '0;
        if (pop_entry.is_load)
        begin
            if (!sending_reg)
            begin
                payload_next = pop_entry.payload;
                pos_next     = '0;
                half_next    = 1'b0;
                sending_next = 1'b1;
            end
        end
        else if (sending_reg)
        begin
            out_next.line_level = bit_val ^ half_reg;
            if (half_reg)
            begin
                half_next = 1'b0;
                pos_next  = pos_inc;
                if (pos_inc >= POS_W'(PACKET_BITS))
                begin
                    sending_next        = 1'b0;
                    pos_next            = '0;
                    out_next.packet_end = 1'b1;
                end
            end
            else
            begin
                half_next = 1'b1;
            end
        end
        out_next.busy_res = sending_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sending_reg   <= 1'b0;
            half_reg      <= 1'b0;
            pos_reg       <= '0;
            payload_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop_ready)
                out_valid_reg <= pop_valid;
            if (take)
            begin
                sending_reg <= sending_next;
                half_reg    <= half_next;
                pos_reg     <= pos_next;
                payload_reg <= payload_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_reg <= out_next;
    end

    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_W'(PACKET_BITS))
        else $error("bit position past end of packet");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !sending_reg |-> (pos_reg == '0 && !half_reg))
        else $error("sequencer idle with stale position");

    a_end_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.packet_end) |-> !out_reg.busy_res)
        else $error("packet end reported while still busy");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (take && out_next.packet_end) |=> !sending_reg)
        else $error("sequencer still sending after packet end");

endmodule

`default_nettype wire
